### rtl/stripe_failure_probability_top_assert.svh
// Assertion macros for the stripe failure probability block.
// Both expect clk and rst_n in the scope of the use.
`ifndef STRIPE_FAILURE_PROBABILITY_TOP_ASSERT_SVH
`define STRIPE_FAILURE_PROBABILITY_TOP_ASSERT_SVH

// Same-cycle implication.
`define SFP_ASSERT_IMP(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("stripe failure probability check failed");

// Next-cycle implication.
`define SFP_ASSERT_NXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("stripe failure probability check failed");

`endif

### rtl/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

    localparam int MAX_DISKS   = 32;
    localparam int COUNT_W     = 6;
    localparam int DATA_W      = 6;
    localparam int PARITY_W    = 5;
    localparam int SPARE_W     = 5;
    localparam int CFG_W       = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_W      = 33;
    localparam int BIN_W       = 30;
    localparam int DVD_W       = 64;
    localparam int STEP_W      = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_DEVICES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARITY_DEVICES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_DEVICES  = 2'd2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 33'h1_0000_0000;

    localparam logic [STEP_W-1:0] BIN_DIV_STEPS  = 7'd36;
    localparam logic [STEP_W-1:0] FRAC_DIV_STEPS = 7'd64;

    typedef struct packed {
        logic [DATA_W-1:0]   data_devices;
        logic [PARITY_W-1:0] parity_devices;
        logic [SPARE_W-1:0]  spare_devices;
    } sfp_cfg_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [BIN_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } sfp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } sfp_div_rsp_t;

endpackage

`default_nettype wire

### rtl/sfp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfp_in_if import sfp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] failed_count;

    modport source (output valid, output failed_count, input ready);
    modport sink (input valid, input failed_count, output ready);
endinterface

`default_nettype wire

### rtl/sfp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfp_out_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] fail_fraction;
    logic              shape_error;

    modport source (output valid, output fail_fraction, output shape_error, input ready);
    modport sink (input valid, input fail_fraction, input shape_error, output ready);
endinterface

`default_nettype wire

### rtl/sfp_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_divider import sfp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  sfp_div_req_t req,
    output sfp_div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [BIN_W-1:0]  rem_reg;
    logic [BIN_W-1:0]  dsr_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [BIN_W:0]    trial;
    logic [BIN_W:0]    diff;
    logic              fits;
    logic [BIN_W-1:0]  rem_next;

    // One quotient bit per cycle, dividend bits enter from the top.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = fits ? diff[BIN_W-1:0] : trial[BIN_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            dvd_reg <= req.dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/sfp_multiplier.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_multiplier import sfp_pkg::*; (
    input  logic                 clk,
    input  logic [BIN_W-1:0]     a,
    input  logic [BIN_W-1:0]     b,
    output logic [2*BIN_W-1:0]   product
);

    logic [2*BIN_W-1:0] product_reg;
    logic [2*BIN_W-1:0] product_next;

    assign product_next = {{BIN_W{1'b0}}, a} * {{BIN_W{1'b0}}, b};

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

### rtl/sfp_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_sequencer import sfp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfp_cfg_t             cfg,
    sfp_in_if.sink               request,
    sfp_out_if.source            result,
    output logic [BIN_W-1:0]     mul_a,
    output logic [BIN_W-1:0]     mul_b,
    input  logic [2*BIN_W-1:0]   mul_product,
    output sfp_div_req_t         div_req,
    input  sfp_div_rsp_t         div_rsp
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_BINIT  = 10'b0000000010,
        S_BLOOP  = 10'b0000000100,
        S_BMUL   = 10'b0000001000,
        S_BDIV   = 10'b0000010000,
        S_TERM   = 10'b0000100000,
        S_TERMW  = 10'b0001000000,
        S_FSTART = 10'b0010000000,
        S_FDIV   = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        P_TOTAL,
        P_B1,
        P_B2
    } purpose_t;

    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [FRAC_W-1:0]  out_frac_reg, out_frac_next;
    logic               out_err_reg, out_err_next;

    purpose_t           purpose_reg, purpose_next;
    logic [5:0]         x_reg, x_next;
    logic [5:0]         n_reg, n_next;
    logic [5:0]         s_reg, s_next;
    logic [4:0]         lim_reg, lim_next;
    logic [4:0]         f_reg, f_next;
    logic [5:0]         bn_reg, bn_next;
    logic [5:0]         br_reg, br_next;
    logic [4:0]         r_reg, r_next;
    logic [4:0]         i_reg, i_next;
    logic [BIN_W-1:0]   acc_reg, acc_next;
    logic [BIN_W-1:0]   tot_reg, tot_next;
    logic [BIN_W-1:0]   b1_reg, b1_next;
    logic [BIN_W:0]     surv_reg, surv_next;
    logic [FRAC_W-1:0]  res_frac_reg, res_frac_next;
    logic               res_err_reg, res_err_next;

    logic [6:0]         s_full;
    logic [6:0]         n_full;
    logic [4:0]         k_val;
    logic [5:0]         bd;
    logic [BIN_W-1:0]   surv_clamp;
    logic [BIN_W-1:0]   fail_count;
    logic               out_load;

    assign k_val  = cfg.parity_devices;
    assign s_full = 7'(cfg.data_devices) + 7'(cfg.parity_devices);
    assign n_full = s_full + 7'(cfg.spare_devices);
    assign bd     = bn_reg - br_reg;

    assign surv_clamp = (surv_reg > {1'b0, tot_reg}) ? tot_reg : surv_reg[BIN_W-1:0];
    assign fail_count = tot_reg - surv_clamp;

    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);

    // The multiplier serves both the binomial steps and the term products.
    assign mul_a = (state_reg == S_TERM) ? b1_reg : acc_reg;
    assign mul_b = (state_reg == S_TERM) ? acc_reg : BIN_W'(bn_reg - 6'(i_reg));

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_BMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_product[35:0], 28'd0};
                div_req.divisor  = BIN_W'(i_reg + 5'd1);
                div_req.steps    = BIN_DIV_STEPS;
            end
            S_FSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b00, fail_count, 32'd0};
                div_req.divisor  = tot_reg;
                div_req.steps    = FRAC_DIV_STEPS;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        purpose_next   = purpose_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        lim_next       = lim_reg;
        f_next         = f_reg;
        bn_next        = bn_reg;
        br_next        = br_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        b1_next        = b1_reg;
        surv_next      = surv_reg;
        res_frac_next  = res_frac_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_frac_next  = out_frac_reg;
        out_err_next   = out_err_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_frac_next  = res_frac_reg;
            out_err_next   = res_err_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    x_next = request.failed_count;
                    if (n_full > 7'(MAX_DISKS))
                    begin
                        res_frac_next = '0;
                        res_err_next  = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else if ({1'b0, request.failed_count} > n_full)
                    begin
                        res_frac_next = FRAC_ONE;
                        res_err_next  = 1'b0;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        n_next       = n_full[5:0];
                        s_next       = s_full[5:0];
                        lim_next     = ({1'b0, k_val} < request.failed_count) ? k_val
                                       : request.failed_count[4:0];
                        bn_next      = n_full[5:0];
                        br_next      = s_full[5:0];
                        purpose_next = P_TOTAL;
                        state_next   = S_BINIT;
                    end
                end
            end
            S_BINIT:
            begin
                i_next = '0;
                if (br_reg > bn_reg)
                begin
                    acc_next = '0;
                    r_next   = '0;
                end
                else
                begin
                    acc_next = BIN_W'(1);
                    r_next   = (br_reg > bd) ? bd[4:0] : br_reg[4:0];
                end
                state_next = S_BLOOP;
            end
            S_BLOOP:
            begin
                if (i_reg == r_reg)
                begin
                    case (purpose_reg)
                        P_TOTAL:
                        begin
                            tot_next     = acc_reg;
                            f_next       = '0;
                            surv_next    = '0;
                            bn_next      = x_reg;
                            br_next      = '0;
                            purpose_next = P_B1;
                            state_next   = S_BINIT;
                        end
                        P_B1:
                        begin
                            b1_next      = acc_reg;
                            bn_next      = n_reg - x_reg;
                            br_next      = s_reg - {1'b0, f_reg};
                            purpose_next = P_B2;
                            state_next   = S_BINIT;
                        end
                        P_B2:
                        begin
                            state_next = S_TERM;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = div_rsp.quotient[BIN_W-1:0];
                    i_next     = i_reg + 5'd1;
                    state_next = S_BLOOP;
                end
            end
            S_TERM:
            begin
                state_next = S_TERMW;
            end
            S_TERMW:
            begin
                surv_next = surv_reg + {1'b0, mul_product[BIN_W-1:0]};
                if (f_reg == lim_reg)
                begin
                    state_next = S_FSTART;
                end
                else
                begin
                    f_next       = f_reg + 5'd1;
                    bn_next      = x_reg;
                    br_next      = {1'b0, f_reg + 5'd1};
                    purpose_next = P_B1;
                    state_next   = S_BINIT;
                end
            end
            S_FSTART:
            begin
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                begin
                    res_frac_next = div_rsp.quotient[FRAC_W-1:0];
                    res_err_next  = 1'b0;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free.
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        purpose_reg  <= purpose_next;
        x_reg        <= x_next;
        n_reg        <= n_next;
        s_reg        <= s_next;
        lim_reg      <= lim_next;
        f_reg        <= f_next;
        bn_reg       <= bn_next;
        br_reg       <= br_next;
        r_reg        <= r_next;
        i_reg        <= i_next;
        acc_reg      <= acc_next;
        tot_reg      <= tot_next;
        b1_reg       <= b1_next;
        surv_reg     <= surv_next;
        res_frac_reg <= res_frac_next;
        res_err_reg  <= res_err_next;
        out_frac_reg <= out_frac_next;
        out_err_reg  <= out_err_next;
    end

    assign request.ready        = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.fail_fraction = out_frac_reg;
    assign result.shape_error   = out_err_reg;

endmodule

`default_nettype wire

### rtl/stripe_failure_probability_top.sv
// Stripe failure probability: for a count of failed devices in a pool of
// data + parity + spare devices, returns the chance that one stripe loses more
// than parity_devices members, as an unsigned fraction times 2^32 (2^32 means
// certain), computed from exact binomial counts. A pool larger than MAX_DISKS
// gives shape_error with a zero fraction; more failures than devices gives 2^32.
// One request is taken at a time. Both special cases go straight from the idle
// state to the finish state. Otherwise the time is set by the shared shift-subtract
// divider, which runs 36 steps for each step of a binomial C(n,r) and 64 steps for
// the final division of the failing count by the total that gives the fraction;
// the sum over f = 0..min(k,x) has at most 32 terms.
// The finished result waits in an output register, and the next request is
// taken meanwhile. The user must write registers through cfg_we, cfg_index,
// cfg_data only while no request is in flight; the block does not enforce this.
// Writes to an index past the list are dropped.
`timescale 1ns / 1ps
`default_nettype none

`include "stripe_failure_probability_top_assert.svh"

module stripe_failure_probability_top import sfp_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    sfp_in_if.sink                 request,
    sfp_out_if.source              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    sfp_cfg_t           cfg_reg, cfg_next;
    logic [BIN_W-1:0]   mul_a;
    logic [BIN_W-1:0]   mul_b;
    logic [2*BIN_W-1:0] mul_product;
    sfp_div_req_t       div_req;
    sfp_div_rsp_t       div_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DATA_DEVICES:   cfg_next.data_devices   = cfg_data;
                CFG_PARITY_DEVICES: cfg_next.parity_devices = cfg_data[PARITY_W-1:0];
                CFG_SPARE_DEVICES:  cfg_next.spare_devices  = cfg_data[SPARE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_devices   <= 6'd4;
            cfg_reg.parity_devices <= 5'd2;
            cfg_reg.spare_devices  <= 5'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfp_multiplier u_multiplier (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product)
    );

    sfp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sfp_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .request     (request),
        .result      (result),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .mul_product (mul_product),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    `SFP_ASSERT_NXT(a_accept_drops_ready, request.valid && request.ready, !request.ready)
    `SFP_ASSERT_IMP(a_shape_zero, result.valid && result.shape_error, result.fail_fraction == 33'd0)
    `SFP_ASSERT_IMP(a_frac_range, result.valid, result.fail_fraction <= FRAC_ONE)
    `SFP_ASSERT_NXT(a_div_single_start, div_req.start, !div_req.start)

endmodule

`default_nettype wire

### sim/tb_stripe_failure_probability_top.sv
`timescale 1ns / 1ps

module tb_stripe_failure_probability_top;
    import sfp_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int IDLE_PCT     = 13;
    localparam int QUIET_LIMIT  = 250000;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLDOFF_LEN  = 600;

    typedef struct packed {
        logic [FRAC_W-1:0] fail_fraction;
        logic              shape_error;
    } loss_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    sfp_in_if  count_if ();
    sfp_out_if loss_if ();

    stripe_failure_probability_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .request(count_if),
        .result(loss_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sfp_cfg_t pool_cfg;
    loss_t    expected_losses[$];
    int       mismatches;
    int       counts_sent;
    int       losses_checked;
    int       shapes_tried;
    int       quiet_cycles;
    int       stall_order;
    bit       steady;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Exact binomial coefficient, zero when r exceeds n.
    function automatic longint unsigned choose(input int unsigned n, input int unsigned r);
        longint unsigned acc;
        int unsigned     half;
        int unsigned     i;
        acc = 1;
        if (r > n)
            return 0;
        half = (r > n - r) ? n - r : r;
        for (i = 0; i < half; i++)
            acc = acc * (n - i) / (i + 1);
        return acc;
    endfunction

    function automatic loss_t predict_loss(input logic [COUNT_W-1:0] failed);
        loss_t           res;
        int unsigned     x;
        int unsigned     k;
        int unsigned     s;
        int unsigned     n;
        int unsigned     lim;
        int unsigned     f;
        longint unsigned total;
        longint unsigned surv;
        res   = '0;
        x     = 32'(failed);
        k     = 32'(pool_cfg.parity_devices);
        s     = 32'(pool_cfg.data_devices) + k;
        n     = s + 32'(pool_cfg.spare_devices);
        if (n > MAX_DISKS)
        begin
            res.shape_error = 1'b1;
            return res;
        end
        if (x > n)
        begin
            res.fail_fraction = FRAC_ONE;
            return res;
        end
        total = choose(n, s);
        surv  = 0;
        lim   = (k < x) ? k : x;
        for (f = 0; f <= lim; f++)
        begin
            if (f > s)
                break;
            surv += choose(x, f) * choose(n - x, s - f);
        end
        if (surv > total)
            surv = total;
        res.fail_fraction = FRAC_W'(((total - surv) << 32) / total);
        return res;
    endfunction

    // Mostly counts the pool can hold; the rest spans the whole field.
    function automatic logic [COUNT_W-1:0] random_count();
        int unsigned n;
        n = 32'(pool_cfg.data_devices) + 32'(pool_cfg.parity_devices)
            + 32'(pool_cfg.spare_devices);
        if (n <= 63 && $urandom_range(99) < 80)
            return COUNT_W'($urandom_range(n));
        return COUNT_W'($urandom_range(63));
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Leaves valid high after the accept edge; the caller drops it or sends again.
    task automatic send_count(input logic [COUNT_W-1:0] failed);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            count_if.valid <= 1'b0;
            @(posedge clk);
        end
        count_if.valid        <= 1'b1;
        count_if.failed_count <= failed;
        @(posedge clk);
        while (!count_if.ready)
            @(posedge clk);
        expected_losses.insert(expected_losses.size(), predict_loss(failed));
        counts_sent++;
    endtask

    task automatic idle_sender();
        count_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_losses.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            CFG_DATA_DEVICES:   pool_cfg.data_devices   = data[DATA_W-1:0];
            CFG_PARITY_DEVICES: pool_cfg.parity_devices = data[PARITY_W-1:0];
            CFG_SPARE_DEVICES:  pool_cfg.spare_devices  = data[SPARE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                             input logic [CFG_W-1:0] spare);
        wait_drained();
        write_reg(CFG_DATA_DEVICES, m);
        write_reg(CFG_PARITY_DEVICES, k);
        write_reg(CFG_SPARE_DEVICES, spare);
        cfg_we <= 1'b0;
        @(posedge clk);
        shapes_tried++;
    endtask

    task automatic test_reset_shape();
        send_count(0);
        send_count(2);
        send_count(3);
        send_count(6);
        send_count(7);
        send_count(63);
        idle_sender();
    endtask

    task automatic test_shape_extremes();
        set_shape(1, 0, 0);
        send_count(0);
        send_count(1);
        idle_sender();
        set_shape(32, 0, 0);
        send_count(0);
        send_count(1);
        send_count(32);
        send_count(33);
        idle_sender();
        set_shape(1, 31, 0);
        send_count(31);
        send_count(32);
        idle_sender();
        set_shape(1, 0, 31);
        send_count(1);
        send_count(16);
        idle_sender();
        // oversized pool, then a data count at the top of its field range
        set_shape(32, 31, 31);
        send_count(5);
        idle_sender();
        set_shape(63, 0, 0);
        send_count(0);
        idle_sender();
        // no data devices: every placement survives
        set_shape(0, 3, 2);
        send_count(2);
        idle_sender();
    endtask

    task automatic test_register_masking();
        // parity and spare keep only their low bits
        set_shape(1, 6'h21, 6'h3E);
        send_count(3);
        idle_sender();
        wait_drained();
        write_reg(CFG_UNUSED_INDEX, 6'h3F);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_count(4);
        idle_sender();
    endtask

    task automatic test_receiver_holdoff();
        set_shape(3, 1, 2);
        stall_order = HOLDOFF_LEN;
        repeat (8) send_count(random_count());
        idle_sender();
    endtask

    task automatic test_drain_pause();
        set_shape(5, 2, 3);
        repeat (6) send_count(random_count());
        idle_sender();
        wait_drained();
        repeat (6) send_count(random_count());
        idle_sender();
    endtask

    task automatic test_random_shapes();
        int phase;
        int i;
        int items;
        int m;
        int k;
        int spare;
        for (phase = 0; phase < 16; phase++)
        begin
            // large pools are slow: keep them few and short
            if (phase % 6 == 5)
            begin
                m     = $urandom_range(32, 1);
                k     = $urandom_range(31);
                spare = $urandom_range(31);
                items = 3;
            end
            else
            begin
                m     = $urandom_range(8, 1);
                k     = $urandom_range(4);
                spare = $urandom_range(6);
                items = 18;
            end
            set_shape(CFG_W'(m), CFG_W'(k), CFG_W'(spare));
            steady = (phase == 3);
            for (i = 0; i < items; i++)
                send_count(random_count());
            idle_sender();
        end
        steady = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        loss_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_order != 0)
            begin
                stall_left  = stall_order;
                stall_order = 0;
            end
            if (stall_left > 0)
            begin
                loss_if.ready <= 1'b0;
                stall_left--;
            end
            else
                loss_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        loss_t exp_loss;
        if (rst_n && loss_if.valid && loss_if.ready)
        begin
            losses_checked++;
            if (expected_losses.size() == 0)
                note_mismatch($sformatf("unexpected result fraction %0d error %0b",
                                        loss_if.fail_fraction, loss_if.shape_error));
            else
            begin
                exp_loss = expected_losses.pop_front();
                if (loss_if.fail_fraction !== exp_loss.fail_fraction
                    || loss_if.shape_error !== exp_loss.shape_error)
                    note_mismatch($sformatf("fraction exp %0d got %0d, error exp %0b got %0b",
                                            exp_loss.fail_fraction, loss_if.fail_fraction,
                                            exp_loss.shape_error, loss_if.shape_error));
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((count_if.valid && count_if.ready) || (loss_if.valid && loss_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        mismatches     = 0;
        counts_sent    = 0;
        losses_checked = 0;
        shapes_tried   = 1;
        quiet_cycles   = 0;
        stall_order    = 0;
        steady         = 1'b0;
        pool_cfg.data_devices   = 4;
        pool_cfg.parity_devices = 2;
        pool_cfg.spare_devices  = 0;
        rst_n                 <= 1'b0;
        count_if.valid        <= 1'b0;
        count_if.failed_count <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_shape();
        test_shape_extremes();
        test_register_masking();
        test_receiver_holdoff();
        test_drain_pause();
        test_random_shapes();

        while (expected_losses.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d failure counts across %0d stripe shapes, checked %0d results",
                 counts_sent, shapes_tried, losses_checked);
        $display("Included oversized pools, zero data devices, masked writes and a long stall; "
                 , "%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_in_if.sv
rtl/sfp_out_if.sv
rtl/sfp_divider.sv
rtl/sfp_multiplier.sv
rtl/sfp_sequencer.sv
rtl/stripe_failure_probability_top.sv
sim/tb_stripe_failure_probability_top.sv
